### rtl/bmmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmmd_pkg;

  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned IndexW    = 21;
  localparam int unsigned RomBankW  = 7;
  localparam int unsigned RamBankW  = 2;
  localparam int unsigned CfgAddrW  = 3;

  localparam logic [AddrW-1:0] EchoLo  = 16'hE000;
  localparam logic [AddrW-1:0] EchoHi  = 16'hFE00;
  localparam logic [AddrW-1:0] EchoOff = 16'h2000;
  localparam logic [AddrW-1:0] VramLo  = 16'h8000;
  localparam logic [AddrW-1:0] ExtLo   = 16'hA000;
  localparam logic [AddrW-1:0] WorkLo  = 16'hC000;
  localparam logic [AddrW-1:0] OamLo   = 16'hFE00;
  localparam logic [AddrW-1:0] HoleLo  = 16'hFEA0;
  localparam logic [AddrW-1:0] IoLo    = 16'hFF00;
  localparam logic [AddrW-1:0] HramLo  = 16'hFF80;
  localparam logic [AddrW-1:0] IeAddr  = 16'hFFFF;

  localparam logic [RomBankW-1:0] RomBankReset = 7'd1;
  localparam logic [DataW-1:0]    RamBankMax   = 8'd3;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MBC1 = 2'd1,
    KIND_MBC2 = 2'd2,
    KIND_MBC3 = 2'd3
  } ctrl_kind_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_CONTROLLER_KIND = 3'd0
  } cfg_addr_e;

  typedef enum logic [3:0] {
    REGION_ROM   = 4'd0,
    REGION_VRAM  = 4'd1,
    REGION_EXT   = 4'd2,
    REGION_WORK  = 4'd3,
    REGION_OAM   = 4'd4,
    REGION_IO    = 4'd5,
    REGION_HRAM  = 4'd6,
    REGION_HOLE  = 4'd7,
    REGION_IE    = 4'd8,
    REGION_BANK  = 4'd9
  } region_e;

  typedef enum logic [1:0] {
    WIN_RAM_ENABLE = 2'd0,
    WIN_ROM_BANK   = 2'd1,
    WIN_RAM_BANK   = 2'd2,
    WIN_MODE       = 2'd3
  } bank_win_e;

  typedef struct packed {
    logic              mode;
    logic [AddrW-1:0]  address;
    logic [DataW-1:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [3:0]        region;
    logic [IndexW-1:0] mem_index;
    logic              mem_write;
    logic [DataW-1:0]  read_value;
  } rsp_t;

  typedef struct packed {
    logic [RomBankW-1:0] rom_bank;
    logic [RamBankW-1:0] ram_bank;
    logic                bank_mode;
    logic [DataW-1:0]    interrupt_enable;
  } bank_state_t;

  typedef struct packed {
    logic              bank_we;
    logic              ie_we;
    bank_win_e         window;
    logic [DataW-1:0]  data;
  } bank_upd_t;

endpackage

`default_nettype wire

### rtl/bmmd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module bmmd_decode
  import bmmd_pkg::*;
(
  input  req_t        req_i,
  input  bank_state_t state_i,
  output rsp_t        rsp_o,
  output bank_upd_t   upd_o
);

  logic [AddrW-1:0] addr;
  logic             wr;
  region_e          region;
  logic [IndexW-1:0] index;
  logic             mem_region;

  assign wr = req_i.mode;

  always_comb begin
    addr = req_i.address;
    if (addr >= EchoLo && addr < EchoHi) begin
      addr = addr - EchoOff;
    end
  end

  always_comb begin
    region     = REGION_HOLE;
    index      = '0;
    mem_region = 1'b0;
    priority if (addr < VramLo) begin
      if (wr) begin
        region = REGION_BANK;
      end else begin
        region = REGION_ROM;
        if (addr[14]) begin
          index = {state_i.rom_bank, addr[13:0]};
        end else begin
          index = {7'd0, addr[13:0]};
        end
      end
    end else if (addr < ExtLo) begin
      region     = REGION_VRAM;
      index      = {8'd0, addr[12:0]};
      mem_region = 1'b1;
    end else if (addr < WorkLo) begin
      region     = REGION_EXT;
      index      = {6'd0, state_i.ram_bank, addr[12:0]};
      mem_region = 1'b1;
    end else if (addr < EchoLo) begin
      region     = REGION_WORK;
      index      = {8'd0, addr[12:0]};
      mem_region = 1'b1;
    end else if (addr < HoleLo) begin
      region     = REGION_OAM;
      index      = {13'd0, addr[7:0]};
      mem_region = 1'b1;
    end else if (addr < IoLo) begin
      region = REGION_HOLE;
    end else if (addr < HramLo) begin
      region     = REGION_IO;
      index      = {14'd0, addr[6:0]};
      mem_region = 1'b1;
    end else if (addr < IeAddr) begin
      region     = REGION_HRAM;
      index      = {14'd0, addr[6:0]};
      mem_region = 1'b1;
    end else begin
      region = REGION_IE;
    end
  end

  always_comb begin
    rsp_o.region     = region;
    rsp_o.mem_index  = index;
    rsp_o.mem_write  = mem_region & wr;
    rsp_o.read_value = '0;
    if (region == REGION_IE) begin
      rsp_o.read_value = wr ? req_i.write_data : state_i.interrupt_enable;
    end
  end

  always_comb begin
    upd_o.bank_we = (region == REGION_BANK);
    upd_o.ie_we   = (region == REGION_IE) & wr;
    upd_o.window  = bank_win_e'(addr[14:13]);
    upd_o.data    = req_i.write_data;
  end

endmodule

`default_nettype wire

### rtl/bmmd_bank_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bmmd_bank_regs
  import bmmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  ctrl_kind_e  kind_i,
  input  bank_upd_t   upd_i,
  output bank_state_t state_o
);

  bank_state_t state_q, state_d;
  logic [DataW-1:0] v;

  assign v = upd_i.data;

  always_comb begin
    state_d = state_q;
    if (fire_i && upd_i.ie_we) begin
      state_d.interrupt_enable = v;
    end
    if (fire_i && upd_i.bank_we) begin
      unique case (kind_i)
        KIND_MBC1: begin
          unique case (upd_i.window)
            WIN_ROM_BANK: begin
              state_d.rom_bank[4:0] = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
            end
            WIN_RAM_BANK: begin
              if (!state_q.bank_mode) begin
                state_d.rom_bank[6:5] = v[1:0];
              end else begin
                state_d.ram_bank = v[1:0];
              end
            end
            WIN_MODE: begin
              state_d.bank_mode = v[0];
              if (v == '0) begin
                state_d.ram_bank = '0;
              end else begin
                state_d.rom_bank[6:5] = 2'd0;
              end
            end
            default: ;
          endcase
        end
        KIND_MBC2: begin
          if (upd_i.window == WIN_ROM_BANK && !v[4]) begin
            state_d.rom_bank = {3'd0, v[3:0]};
          end
        end
        KIND_MBC3: begin
          if (upd_i.window == WIN_ROM_BANK) begin
            state_d.rom_bank = v[6:0];
          end else if (upd_i.window == WIN_RAM_BANK && v <= RamBankMax) begin
            state_d.ram_bank = v[1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.rom_bank         <= RomBankReset;
      state_q.ram_bank         <= '0;
      state_q.bank_mode        <= 1'b0;
      state_q.interrupt_enable <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

### rtl/banked_memory_map_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes one 8-bit bus access a beat into its memory region and the physical byte index
// within that region, and keeps the ROM/RAM bank registers and the interrupt-enable byte.
// Each beat is captured in an input register and then decoded into a result register, so a
// new beat can be taken every cycle while the output is not stalled; the bank registers
// change in the decode cycle, so the next beat sees them. The controller kind is written
// over the APB port at offset 0, by the user only while no beat is pending; not enforced.

module banked_memory_map_decoder
  import bmmd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  req_t                in_data_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsp_t                out_data_o
);

  ctrl_kind_e  kind_q;
  logic        cfg_we;

  req_t        req_q;
  logic        req_valid_q;
  rsp_t        rsp_q, rsp_d;
  logic        rsp_valid_q;
  logic        advance;
  bank_state_t state;
  bank_upd_t   upd;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr == CFG_CONTROLLER_KIND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_NONE;
    end else if (cfg_we) begin
      kind_q <= ctrl_kind_e'(pwdata[1:0]);
    end
  end

  assign prdata = (paddr == CFG_CONTROLLER_KIND) ? {30'd0, kind_q} : 32'd0;

  assign advance    = req_valid_q & (~rsp_valid_q | out_ready_i);
  assign in_ready_o = ~req_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_data_i;
    end
  end

  bmmd_decode u_decode (
    .req_i   (req_q),
    .state_i (state),
    .rsp_o   (rsp_d),
    .upd_o   (upd)
  );

  bmmd_bank_regs u_bank_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .kind_i  (kind_q),
    .upd_i   (upd),
    .state_o (state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_data_o  = rsp_q;

endmodule

`default_nettype wire
